// ===== rtl/core/snz_pkg.sv =====
// Shared types and constants for the 2-D simplex noise block.
// Used by snz_front, snz_mod, snz_back and simplex_noise_2d_q16_top; no dependencies.
package snz_pkg;

  localparam int WIDTH            = 32;
  localparam int PERM_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [15:0] SKEW_RST   = 16'd23988;
  localparam logic [15:0] UNSKEW_RST = 16'd13849;
  localparam logic [31:0] GRAD_RST   = 32'hC431FD75;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  localparam logic [1:0] CFG_SKEW   = 2'd0;
  localparam logic [1:0] CFG_UNSKEW = 2'd1;
  localparam logic [1:0] CFG_GRAD   = 2'd2;

  typedef struct packed {
    logic                    kind;
    logic signed [WIDTH-1:0] x;
    logic signed [WIDTH-1:0] y;
    logic [7:0]              pidx;
    logic [7:0]              pval;
  } item_t;

  typedef struct packed {
    logic [15:0] skew;
    logic [15:0] unskew;
    logic [31:0] grad;
  } cfg_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic pop;
    logic ready;
  } back_stat_t;

endpackage

// ===== rtl/core/snz_front.sv =====
// Front end: accepts items, drops out-of-range loads and queues the rest.
// Depends on snz_pkg.
module snz_front #(
  parameter int PERM_ENTRIES = snz_pkg::PERM_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  snz_pkg::item_t      in_item,
  output logic                q_valid,
  output snz_pkg::item_t      q_item,
  input  snz_pkg::back_stat_t stat
);

  localparam int DEPTH = 4;
  localparam int PW    = 2;

  snz_pkg::item_t fifo [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           keep;
  logic           push;

  // A load outside the table is consumed here and never reaches the back end.
  assign keep     = (in_item.kind == snz_pkg::KIND_SAMPLE) ||
                    ({24'd0, in_item.pidx} < 32'(PERM_ENTRIES));
  assign in_ready = (count != (PW+1)'(DEPTH)) && stat.ready;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (stat.pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !stat.pop) count <= count + 1'b1;
      else if (!push && stat.pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= in_item;
  end

endmodule

// ===== rtl/core/snz_mod.sv =====
// Two-stage unsigned 32-bit modulo by the table size, using a reciprocal
// multiply and one correction step. Depends on snz_pkg.
module snz_mod #(
  parameter int PERM_ENTRIES = snz_pkg::PERM_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [snz_pkg::WIDTH-1:0]       value,
  output logic [$clog2(PERM_ENTRIES)-1:0] result
);

  localparam int AW = $clog2(PERM_ENTRIES);
  localparam longint unsigned RCP_L = (64'd1 << 32) / PERM_ENTRIES;
  localparam logic [31:0] RCP = RCP_L[31:0];
  localparam logic [AW:0] NW  = (AW+1)'(PERM_ENTRIES);

  logic [63:0] prod;
  logic [31:0] quot;
  logic [AW:0] low;
  logic [AW:0] qn;
  logic [AW:0] rem;

  // The quotient estimate is at most one short, so the remainder stays below 2N.
  assign prod = 64'(value) * 64'(RCP);
  assign qn   = quot[AW:0] * NW;
  assign rem  = low - qn;

  always_ff @(posedge clk) begin
    if (en) begin
      quot   <= prod[63:32];
      low    <= value[AW:0];
      result <= (rem >= NW) ? AW'(rem - NW) : AW'(rem);
    end
  end

endmodule

// ===== rtl/core/snz_back.sv =====
// Back end: skew, corner search, two-level permutation hashing and falloff sum.
// Depends on snz_pkg and snz_mod; holds the permutation table copies.
module snz_back #(
  parameter int PERM_ENTRIES = snz_pkg::PERM_ENTRIES_DEF,
  parameter int FRAC_BITS    = snz_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  snz_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  snz_pkg::item_t      q_item,
  output snz_pkg::back_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_level
);

  localparam int AW = $clog2(PERM_ENTRIES);
  localparam int D  = 18;
  localparam logic [31:0] ONE   = 32'd1 << FRAC_BITS;
  localparam logic [31:0] HALF  = 32'd1 << (FRAC_BITS - 1);
  localparam logic [31:0] FMASK = ONE - 32'd1;
  localparam logic [31:0] MUL_SUM   = 32'd70;
  localparam logic [31:0] MUL_LEVEL = 32'd127;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p[FRAC_BITS+31:FRAC_BITS];
  endfunction

  function automatic logic signed [31:0] term(input logic signed [31:0] p,
                                              input logic [1:0] g);
    logic signed [31:0] r;
    case (g)
      2'b00:   r = '0;
      2'b01:   r = p;
      2'b11:   r = -p;
      2'b10:   r = -(p <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  logic adv;
  logic clearing;
  logic [AW-1:0] clr_cnt;
  logic vld [1:D];
  logic knd [1:D];
  logic [7:0] pidxd [1:12];
  logic [7:0] pvald [1:12];

  logic signed [31:0] x1, y1, sxy1, x2, y2, s2;
  logic signed [31:0] x3, y3, ci3, cj3, cij3;
  logic signed [31:0] x4, y4, ci4, cj4, t4v;
  logic signed [31:0] ci5, cj5, xp5, yp5;
  logic signed [31:0] sx3, sy3;
  logic signed [31:0] px6 [3];
  logic signed [31:0] py6 [3];
  logic signed [31:0] ii6 [3];
  logic signed [31:0] jj6 [3];
  logic signed [31:0] iid [7:9][3];
  logic signed [31:0] pxd [7:13][3];
  logic signed [31:0] pyd [7:13][3];
  logic signed [31:0] sqx7 [3];
  logic signed [31:0] sqy7 [3];
  logic signed [31:0] t8 [3];
  logic signed [31:0] t2_9 [3];
  logic signed [31:0] t4d [10:14][3];
  logic               zd [8:14][3];
  logic [AW-1:0]      addr8 [3];
  logic [AW-1:0]      addr12 [3];
  logic [7:0]         p9 [3];
  logic [31:0]        sum10 [3];
  logic [2:0]         h13 [3];
  logic signed [31:0] dot14 [3];
  logic signed [31:0] c15 [3];
  logic signed [31:0] sum16, m17;
  logic [31:0]        lvl_prod;
  logic [7:0]         mem1 [3][PERM_ENTRIES];
  logic [7:0]         mem2 [3][PERM_ENTRIES];
  logic               wr1_en, wr2_en;
  logic [AW-1:0]      wr1_addr, wr2_addr;
  logic [7:0]         wr1_data, wr2_data;

  // Stage 6 corner geometry.
  logic               gt6;
  logic signed [31:0] ioff6, joff6, uns6;

  assign adv        = !(out_valid && !out_ready);
  assign out_valid  = vld[D] && (knd[D] == snz_pkg::KIND_SAMPLE);
  assign stat.pop   = adv && q_valid && !clearing;
  assign stat.ready = !clearing;

  assign sx3 = x2 + s2;
  assign sy3 = y2 + s2;

  always_comb begin
    gt6   = xp5 > yp5;
    ioff6 = gt6 ? $signed(ONE) : 32'sd0;
    joff6 = gt6 ? 32'sd0 : $signed(ONE);
    uns6  = $signed({16'd0, cfg.unskew});
  end

  assign lvl_prod = m17 * MUL_LEVEL;

  // Control: valid line and the clearing pass that loads the identity table.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      for (int i = 1; i <= D; i++) begin
        vld[i] <= 1'b0;
        knd[i] <= snz_pkg::KIND_SAMPLE;
      end
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AW'(PERM_ENTRIES - 1)) clearing <= 1'b0;
      end
      if (adv) begin
        vld[1] <= q_valid && !clearing;
        knd[1] <= q_item.kind;
        for (int i = 2; i <= D; i++) begin
          vld[i] <= vld[i-1];
          knd[i] <= knd[i-1];
        end
      end
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      pidxd[1] <= q_item.pidx;
      pvald[1] <= q_item.pval;
      for (int i = 2; i <= 12; i++) begin
        pidxd[i] <= pidxd[i-1];
        pvald[i] <= pvald[i-1];
      end
      x1   <= q_item.x;
      y1   <= q_item.y;
      sxy1 <= q_item.x + q_item.y;
      x2   <= x1;
      y2   <= y1;
      s2   <= qmul(sxy1, $signed({16'd0, cfg.skew}));
      x3   <= x2;
      y3   <= y2;
      ci3  <= sx3 & ~FMASK;
      cj3  <= sy3 & ~FMASK;
      cij3 <= (sx3 & ~FMASK) + (sy3 & ~FMASK);
      x4   <= x3;
      y4   <= y3;
      ci4  <= ci3;
      cj4  <= cj3;
      t4v  <= qmul(cij3, $signed({16'd0, cfg.unskew}));
      ci5  <= ci4;
      cj5  <= cj4;
      xp5  <= x4 - (ci4 - t4v);
      yp5  <= y4 - (cj4 - t4v);
      px6[0] <= xp5;
      py6[0] <= yp5;
      px6[1] <= xp5 - ioff6 + uns6;
      py6[1] <= yp5 - joff6 + uns6;
      px6[2] <= xp5 - $signed(ONE) + (uns6 <<< 1);
      py6[2] <= yp5 - $signed(ONE) + (uns6 <<< 1);
      ii6[0] <= ci5 >>> FRAC_BITS;
      jj6[0] <= cj5 >>> FRAC_BITS;
      ii6[1] <= (ci5 + ioff6) >>> FRAC_BITS;
      jj6[1] <= (cj5 + joff6) >>> FRAC_BITS;
      ii6[2] <= (ci5 >>> FRAC_BITS) + 32'sd1;
      jj6[2] <= (cj5 >>> FRAC_BITS) + 32'sd1;
      iid[7] <= ii6;
      iid[8] <= iid[7];
      iid[9] <= iid[8];
      pxd[7] <= px6;
      pyd[7] <= py6;
      for (int i = 8; i <= 13; i++) begin
        pxd[i] <= pxd[i-1];
        pyd[i] <= pyd[i-1];
      end
      for (int k = 0; k < 3; k++) begin
        sqx7[k]   <= qmul(px6[k], px6[k]);
        sqy7[k]   <= qmul(py6[k], py6[k]);
        t8[k]     <= $signed(HALF) - sqx7[k] - sqy7[k];
        zd[8][k]  <= ($signed(HALF) - sqx7[k] - sqy7[k]) < 0;
        t2_9[k]   <= qmul(t8[k], t8[k]);
        t4d[10][k] <= qmul(t2_9[k], t2_9[k]);
        sum10[k]  <= iid[9][k] + $signed({24'd0, p9[k]});
        dot14[k]  <= term(pxd[13][k], cfg.grad[{h13[k], 2'b10} +: 2]) +
                     term(pyd[13][k], cfg.grad[{h13[k], 2'b00} +: 2]);
        c15[k]    <= zd[14][k] ? 32'sd0 : qmul(t4d[14][k], dot14[k]);
      end
      for (int i = 9; i <= 14; i++) zd[i] <= zd[i-1];
      for (int i = 11; i <= 14; i++) t4d[i] <= t4d[i-1];
      sum16     <= c15[0] + c15[1] + c15[2];
      m17       <= sum16 * $signed(MUL_SUM) + $signed(ONE);
      out_level <= lvl_prod[FRAC_BITS+7:FRAC_BITS];
    end
  end

  // Permutation table copies. Loads write the first-level copies when they
  // reach the first read stage and the second-level copies at the second,
  // so every sample sees exactly the loads that came before it.
  assign wr1_en   = clearing || (adv && vld[8] && (knd[8] == snz_pkg::KIND_LOAD));
  assign wr1_addr = clearing ? clr_cnt : AW'(pidxd[8]);
  assign wr1_data = clearing ? 8'(clr_cnt) : pvald[8];
  assign wr2_en   = clearing || (adv && vld[12] && (knd[12] == snz_pkg::KIND_LOAD));
  assign wr2_addr = clearing ? clr_cnt : AW'(pidxd[12]);
  assign wr2_data = clearing ? 8'(clr_cnt) : pvald[12];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (wr1_en) mem1[k][wr1_addr] <= wr1_data;
      if (adv) p9[k] <= mem1[k][addr8[k]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (wr2_en) mem2[k][wr2_addr] <= wr2_data;
      if (adv) h13[k] <= mem2[k][addr12[k]][2:0];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_hash
    snz_mod #(.PERM_ENTRIES(PERM_ENTRIES)) u_mod1 (
      .clk    (clk),
      .en     (adv),
      .value  (jj6[k]),
      .result (addr8[k])
    );
    snz_mod #(.PERM_ENTRIES(PERM_ENTRIES)) u_mod2 (
      .clk    (clk),
      .en     (adv),
      .value  (sum10[k]),
      .result (addr12[k])
    );
  end

endmodule

// ===== rtl/core/simplex_noise_2d_q16_top.sv =====
// Top level of the 2-D simplex noise generator (signed Q16.16 coordinates).
// An accepted sample passes through the front-end queue and then the back-end pipeline.
// Throughput: one item per cycle unless stalled; the 18-stage back end sets it.
// Reset is synchronous; afterwards a clearing pass writes the identity
// permutation into every table entry, and no item is accepted until it ends.
// Depends on snz_pkg, snz_front, snz_back and snz_mod.
module simplex_noise_2d_q16_top #(
  parameter int PERM_ENTRIES = snz_pkg::PERM_ENTRIES_DEF,
  parameter int FRAC_BITS    = snz_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. tdata from bit 0: coord_x[31:0], coord_y[31:0],
  // perm_index[7:0], perm_value[7:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  // tuser: kind (0 sample, 1 load).
  input  logic        s_axis_tuser,
  // Output stream. tdata from bit 0: noise_level[7:0].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  snz_pkg::cfg_t       cfg;
  snz_pkg::item_t      in_item;
  snz_pkg::item_t      q_item;
  snz_pkg::back_stat_t stat;
  logic                q_valid;

  // Configuration is taken on every cycle; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skew   <= snz_pkg::SKEW_RST;
      cfg.unskew <= snz_pkg::UNSKEW_RST;
      cfg.grad   <= snz_pkg::GRAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        snz_pkg::CFG_SKEW:   cfg.skew   <= cfg_data[15:0];
        snz_pkg::CFG_UNSKEW: cfg.unskew <= cfg_data[15:0];
        snz_pkg::CFG_GRAD:   cfg.grad   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack one input transaction into its fields.
  assign in_item.kind = s_axis_tuser;
  assign in_item.x    = $signed(s_axis_tdata[31:0]);
  assign in_item.y    = $signed(s_axis_tdata[63:32]);
  assign in_item.pidx = s_axis_tdata[71:64];
  assign in_item.pval = s_axis_tdata[79:72];

  // The front end queues items so the input keeps flowing while the
  // back end holds a result the downstream side has not yet taken.
  snz_front #(.PERM_ENTRIES(PERM_ENTRIES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .stat     (stat)
  );

  snz_back #(.PERM_ENTRIES(PERM_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_level (m_axis_tdata)
  );

endmodule
